[hdl/jsfe_pkg.sv]
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types and constants of the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

    localparam int DEF_MAX_KEY_BYTES = 16;
    // key bytes the two key registers can hold
    localparam int KEY_REG_BYTES     = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES_HIGH = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_CLOSED    = 2'd1,
        KIND_CUT       = 2'd2,
        KIND_NOT_FOUND = 2'd3
    } kind_t;

    // results caused by one text byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        kind_t      kind0;
        logic [7:0] byte0;
        kind_t      kind1;
    } run_t;

endpackage

[hdl/jsfe_front.sv]
// ----------------------------------------------------------------------------
// jsfe_front
// Key window match, value parse state and unescaping; builds one run record
// for each text byte.
// ----------------------------------------------------------------------------
module jsfe_front
    import jsfe_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 take,
    input  logic [7:0]           text_byte,
    input  logic                 frame_end,
    output logic                 push,
    output run_t                 run
);

    localparam int WIN_DEPTH  = MAX_KEY_BYTES + 4;
    localparam int LEN_W      = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int HEX_DIGITS = 4;
    localparam int HCNT_W     = $clog2(HEX_DIGITS);
    localparam logic [HCNT_W-1:0] HEX_LAST = HCNT_W'(HEX_DIGITS - 1);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        M_SEARCH = 3'd0,
        M_VALUE  = 3'd1,
        M_ESCAPE = 3'd2,
        M_HEX    = 3'd3,
        M_DONE   = 3'd4
    } mode_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    logic [4:0]        key_length_reg;
    logic [63:0]       key_low_reg;
    logic [63:0]       key_high_reg;
    logic [127:0]      key_cat;
    logic [7:0]        key_arr [MAX_KEY_BYTES];
    logic [LEN_W-1:0]  len_eff;
    logic [KIDX_W-1:0] kpos;

    mode_t             mode_reg, mode_next;
    logic [HCNT_W-1:0] hcnt_reg, hcnt_next;
    logic [7:0]        win_reg  [WIN_DEPTH];
    logic [7:0]        win_next [WIN_DEPTH];
    logic [7:0]        win_sh   [WIN_DEPTH];
    logic              hit;

    logic              r0_valid, do_value, e_valid;
    kind_t             r0_kind, e_kind;
    logic [7:0]        r0_byte;

    assign key_cat = {key_high_reg, key_low_reg};

    for (genvar k = 0; k < MAX_KEY_BYTES; k++) begin : g_key
        if (k < KEY_REG_BYTES) begin : g_held
            assign key_arr[k] = key_cat[8*k +: 8];
        end else begin : g_zero
            assign key_arr[k] = 8'h00;
        end
    end

    assign len_eff = (32'(key_length_reg) > MAX_KEY_BYTES) ? LEN_W'(MAX_KEY_BYTES)
                                                           : LEN_W'(key_length_reg);

    always_comb begin
        win_sh[0] = text_byte;
        for (int i = 1; i < WIN_DEPTH; i++) begin
            win_sh[i] = win_reg[i-1];
        end
    end

    // newest byte at index 0, so the key appears reversed behind the quote-colon-quote
    always_comb begin
        kpos = '0;
        hit  = (win_sh[0] == CH_QUOTE) && (win_sh[1] == CH_COLON) && (win_sh[2] == CH_QUOTE);
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            if (i < int'(len_eff)) begin
                kpos = KIDX_W'(int'(len_eff) - 1 - i);
                if (win_sh[3+i] != key_arr[kpos]) begin
                    hit = 1'b0;
                end
            end
        end
        for (int i = 0; i <= MAX_KEY_BYTES; i++) begin
            if (i == int'(len_eff) && win_sh[3+i] != CH_QUOTE) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        mode_next = mode_reg;
        hcnt_next = hcnt_reg;
        win_next  = win_reg;
        r0_valid  = 1'b0;
        r0_kind   = KIND_BYTE;
        r0_byte   = 8'h00;
        do_value  = 1'b0;
        e_valid   = 1'b0;
        e_kind    = KIND_CUT;

        case (mode_reg)
            M_SEARCH: begin
                win_next = win_sh;
                if (hit) begin
                    mode_next = M_VALUE;
                end
            end
            M_VALUE: begin
                do_value = 1'b1;
            end
            M_ESCAPE: begin
                mode_next = M_VALUE;
                priority if (text_byte == CH_N) begin
                    r0_valid = 1'b1;
                    r0_byte  = CH_LF;
                end else if (text_byte == CH_T || text_byte == CH_R) begin
                    r0_valid = 1'b1;
                    r0_byte  = CH_SPACE;
                end else if (text_byte == CH_BSL || text_byte == CH_QUOTE ||
                             text_byte == CH_SLASH) begin
                    r0_valid = 1'b1;
                    r0_byte  = text_byte;
                end else if (text_byte == CH_U) begin
                    r0_valid  = 1'b1;
                    r0_byte   = CH_SPACE;
                    mode_next = M_HEX;
                    hcnt_next = '0;
                end else begin
                    // unknown escape dropped
                end
            end
            M_HEX: begin
                if (is_hex(text_byte)) begin
                    if (hcnt_reg == HEX_LAST) begin
                        mode_next = M_VALUE;
                        hcnt_next = '0;
                    end else begin
                        hcnt_next = hcnt_reg + 1'b1;
                    end
                end else begin
                    mode_next = M_VALUE;
                    hcnt_next = '0;
                    do_value  = 1'b1;
                end
            end
            M_DONE: begin
            end
            default: begin
                mode_next = M_DONE;
            end
        endcase

        if (do_value) begin
            priority if (text_byte == CH_QUOTE) begin
                mode_next = M_DONE;
                r0_valid  = 1'b1;
                r0_kind   = KIND_CLOSED;
            end else if (text_byte == CH_BSL) begin
                mode_next = M_ESCAPE;
            end else begin
                r0_valid = 1'b1;
                r0_byte  = text_byte;
            end
        end

        if (frame_end) begin
            if (mode_next == M_SEARCH) begin
                e_valid = 1'b1;
                e_kind  = KIND_NOT_FOUND;
            end else if (mode_next != M_DONE) begin
                e_valid = 1'b1;
                e_kind  = KIND_CUT;
            end
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_next[i] = 8'h00;
            end
            mode_next = M_SEARCH;
            hcnt_next = '0;
        end
    end

    always_comb begin
        if (r0_valid) begin
            run.count = 2'd1 + {1'b0, e_valid};
            run.kind0 = r0_kind;
            run.byte0 = r0_byte;
        end else begin
            run.count = {1'b0, e_valid};
            run.kind0 = e_kind;
            run.byte0 = 8'h00;
        end
        run.kind1 = e_kind;
    end

    assign push = take && (run.count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= '0;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            mode_reg       <= M_SEARCH;
            hcnt_reg       <= '0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_reg[i] <= 8'h00;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_KEY_LENGTH:     key_length_reg <= cfg_data[4:0];
                    CFG_KEY_BYTES_LOW:  key_low_reg    <= cfg_data;
                    CFG_KEY_BYTES_HIGH: key_high_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (take) begin
                mode_reg <= mode_next;
                hcnt_reg <= hcnt_next;
                win_reg  <= win_next;
            end
        end
    end

endmodule

[hdl/jsfe_queue.sv]
// ----------------------------------------------------------------------------
// jsfe_queue
// Small first-in first-out queue of run records between front and back.
// ----------------------------------------------------------------------------
module jsfe_queue
    import jsfe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  run_t run_in,
    input  logic pop,
    output run_t head,
    output logic empty,
    output logic full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    run_t             store [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head    = store[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= run_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

[hdl/jsfe_back.sv]
// ----------------------------------------------------------------------------
// jsfe_back
// Splits run records into single results and drives the output register.
// ----------------------------------------------------------------------------
module jsfe_back
    import jsfe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  run_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_value_byte,
    output logic       m_last_of_run
);

    logic       m_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       phase_reg;
    logic       load, cur_last;
    kind_t      cur_kind;
    logic [7:0] cur_byte;

    // output register can take a new result when empty or being drained
    assign load     = !m_valid_reg || m_ready;
    assign cur_kind = phase_reg ? head.kind1 : head.kind0;
    assign cur_byte = phase_reg ? 8'h00 : head.byte0;
    assign cur_last = phase_reg || (head.count == 2'd1);
    assign pop      = load && !empty && cur_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else if (load) begin
            m_valid_reg <= !empty;
            if (!empty) begin
                phase_reg <= !cur_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            kind_reg <= cur_kind;
            byte_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_value_byte  = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

[hdl/json_string_field_extractor.sv]
// ----------------------------------------------------------------------------
// json_string_field_extractor
// Finds a configured key in streamed JSON text and emits its unescaped string
// value followed by one end status per frame.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: write key_length (index 0), key_bytes_low (1), key_bytes_high (2)
//   while no frame is in flight; cfg_ready is always high.
//   s channel: one text byte per transfer, s_frame_end on the last byte of a frame.
//   m channel: results of kind 0 (value byte), 1 (closed by quote), 2 (cut by
//   frame end) or 3 (key not found); m_last_of_run marks the final result
//   caused by one input byte.
// Timing:
//   the first result of a byte passes the run queue, then the output register.
//   one byte is accepted per cycle while the queue is not full; a byte giving two
//   results (a frame end only) emits both, absorbed by a four-entry run queue.
//   the key match over the byte window and the parse step are combinational.
// Reset: window cleared, parser searching, key registers zero, queue empty.
// Stall: while m_ready is low results wait in the output register and the
//   queue; s_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module json_string_field_extractor
    import jsfe_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_frame_end,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_value_byte,
    output logic                 m_last_of_run
);

    logic take, push, pop, empty, full;
    run_t run, head;

    assign cfg_ready = 1'b1;
    assign s_ready   = !full;
    assign take      = s_valid && s_ready;

    jsfe_front #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .text_byte (s_text_byte),
        .frame_end (s_frame_end),
        .push      (push),
        .run       (run)
    );

    jsfe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .run_in  (run),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    jsfe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_value_byte  (m_value_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string field extractor. A directed table of
// text bytes runs first, then random frames (mostly well-formed key/value text
// with random escapes, truncations and noise) under several key settings.
// Results are checked against an in-bench parser model or typed table rows.
// ----------------------------------------------------------------------------
module tb
    import jsfe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_KEY        = DEF_MAX_KEY_BYTES;
    localparam int WIN_DEPTH      = DEF_MAX_KEY_BYTES + 4;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 155;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        PM_SEARCH,
        PM_VALUE,
        PM_ESCAPE,
        PM_HEX,
        PM_DONE
    } parse_mode_e;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] vbyte;
        logic       last;
    } field_result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fend;
        logic       typed;
        kind_t      want;
    } text_row_t;

    // reset key (empty key), so the pattern to find is "":"
    localparam text_row_t DIRECTED [25] = '{
        '{8'h00,     1'b1, 1'b1, KIND_NOT_FOUND},
        '{8'hFF,     1'b1, 1'b1, KIND_NOT_FOUND},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE},
        '{CH_COLON,  1'b0, 1'b0, KIND_BYTE},
        '{CH_QUOTE,  1'b1, 1'b1, KIND_CUT},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE},
        '{CH_COLON,  1'b0, 1'b0, KIND_BYTE},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE},
        '{8'h00,     1'b0, 1'b0, KIND_BYTE},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE},
        '{"n",       1'b0, 1'b0, KIND_BYTE},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE},
        '{"t",       1'b0, 1'b0, KIND_BYTE},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE},
        '{"u",       1'b0, 1'b0, KIND_BYTE},
        '{"1",       1'b0, 1'b0, KIND_BYTE},
        '{"g",       1'b0, 1'b0, KIND_BYTE},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE},
        '{"x",       1'b0, 1'b0, KIND_BYTE},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE},
        '{"z",       1'b1, 1'b0, KIND_BYTE}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_text_byte;
    logic                 s_frame_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_kind;
    logic [7:0]           m_value_byte;
    logic                 m_last_of_run;

    // parser model state and its copy of the key registers
    logic [7:0]    recent_text [WIN_DEPTH];
    parse_mode_e   pmode;
    int unsigned   hex_seen;
    logic [4:0]    key_len_q;
    logic [63:0]   key_lo_q;
    logic [63:0]   key_hi_q;

    field_result_t byte_results[$];
    field_result_t extracted_q[$];
    logic [7:0]    frame_text[$];

    int  err_count = 0;
    int  n_items   = 0;
    int  n_frames  = 0;
    int  kind_seen [4] = '{0, 0, 0, 0};
    int  hold_req  = 0;
    bit  idle_on   = 1'b1;

    json_string_field_extractor DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_value_byte  (m_value_byte),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] key_byte(int k);
        if (k < 8) begin
            return key_lo_q[8*k +: 8];
        end
        return key_hi_q[8*(k-8) +: 8];
    endfunction

    function automatic int key_span();
        return (key_len_q > MAX_KEY) ? MAX_KEY : int'(key_len_q);
    endfunction

    function automatic bit is_hex(logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic void add_result(kind_t k, logic [7:0] v);
        field_result_t r;
        r.kind  = k;
        r.vbyte = (k == KIND_BYTE) ? v : 8'h00;
        r.last  = 1'b0;
        byte_results.push_back(r);
    endfunction

    // newest byte sits at index 0, so the key appears reversed behind ":"
    function automatic bit key_found();
        int len;
        bit hit;
        len = key_span();
        hit = recent_text[0] == CH_QUOTE && recent_text[1] == CH_COLON &&
              recent_text[2] == CH_QUOTE;
        for (int i = 0; i < len; i++) begin
            if (recent_text[3+i] != key_byte(len - 1 - i)) hit = 1'b0;
        end
        return hit && recent_text[3+len] == CH_QUOTE;
    endfunction

    function automatic void value_char(logic [7:0] b);
        if (b == CH_QUOTE) begin
            pmode = PM_DONE;
            add_result(KIND_CLOSED, 8'h00);
        end else if (b == CH_BSLASH) begin
            pmode = PM_ESCAPE;
        end else begin
            add_result(KIND_BYTE, b);
        end
    endfunction

    function automatic void extract_byte(logic [7:0] b, logic fend);
        byte_results.delete();
        case (pmode)
            PM_SEARCH: begin
                for (int i = WIN_DEPTH - 1; i > 0; i--) recent_text[i] = recent_text[i-1];
                recent_text[0] = b;
                if (key_found()) pmode = PM_VALUE;
            end
            PM_VALUE: value_char(b);
            PM_ESCAPE: begin
                pmode = PM_VALUE;
                if (b == "n") begin
                    add_result(KIND_BYTE, CH_LF);
                end else if (b == "t" || b == "r") begin
                    add_result(KIND_BYTE, CH_SPACE);
                end else if (b == CH_BSLASH || b == CH_QUOTE || b == CH_SLASH) begin
                    add_result(KIND_BYTE, b);
                end else if (b == "u") begin
                    add_result(KIND_BYTE, CH_SPACE);
                    pmode    = PM_HEX;
                    hex_seen = 0;
                end
            end
            PM_HEX: begin
                if (is_hex(b) && hex_seen < 4) begin
                    hex_seen++;
                    if (hex_seen >= 4) begin
                        pmode    = PM_VALUE;
                        hex_seen = 0;
                    end
                end else begin
                    pmode    = PM_VALUE;
                    hex_seen = 0;
                    value_char(b);
                end
            end
            default: pmode = PM_DONE;
        endcase
        if (fend) begin
            if (pmode == PM_SEARCH) begin
                add_result(KIND_NOT_FOUND, 8'h00);
            end else if (pmode != PM_DONE) begin
                add_result(KIND_CUT, 8'h00);
            end
            foreach (recent_text[i]) recent_text[i] = 8'h00;
            pmode    = PM_SEARCH;
            hex_seen = 0;
        end
        if (byte_results.size() > 0) byte_results[byte_results.size()-1].last = 1'b1;
    endfunction

    function automatic logic [63:0] letters64();
        logic [63:0] v;
        for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'($urandom_range("a", "z"));
        return v;
    endfunction

    // mostly "<key>":"<value>" with random escapes; some noise and cut frames
    function automatic void build_frame();
        int          len;
        int          pick;
        int          cut;
        logic [7:0]  c;
        string       hexd  = "0123456789abcdefABCDEF";
        string       esc   = "ntr\\\"/u";
        string       punct = " {}[],:\"a1";
        frame_text.delete();
        len = key_span();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) frame_text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3))
            frame_text.push_back(punct[$urandom_range(0, punct.len() - 1)]);
        if (len > 0 && $urandom_range(0, 3) == 0) begin
            // near miss: one key byte altered
            pick = $urandom_range(0, len - 1);
            frame_text.push_back(CH_QUOTE);
            for (int i = 0; i < len; i++)
                frame_text.push_back(key_byte(i) ^ ((i == pick) ? 8'h01 : 8'h00));
            frame_text.push_back(CH_QUOTE);
            frame_text.push_back(CH_COLON);
            frame_text.push_back(CH_QUOTE);
        end
        frame_text.push_back(CH_QUOTE);
        for (int i = 0; i < len; i++) frame_text.push_back(key_byte(i));
        frame_text.push_back(CH_QUOTE);
        frame_text.push_back(CH_COLON);
        frame_text.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
                frame_text.push_back(c);
            end else begin
                frame_text.push_back(CH_BSLASH);
                if (pick == 9) begin
                    frame_text.push_back(8'($urandom_range(0, 255)));
                end else begin
                    c = esc[$urandom_range(0, esc.len() - 1)];
                    frame_text.push_back(c);
                    if (c == "u") begin
                        repeat ($urandom_range(0, 5))
                            frame_text.push_back(hexd[$urandom_range(0, hexd.len() - 1)]);
                        if ($urandom_range(0, 2) == 0)
                            frame_text.push_back(punct[$urandom_range(0, punct.len() - 1)]);
                    end
                end
            end
        end
        if ($urandom_range(0, 6) != 0) begin
            frame_text.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 3))
                frame_text.push_back(punct[$urandom_range(0, punct.len() - 1)]);
        end
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, frame_text.size());
            while (frame_text.size() > cut) void'(frame_text.pop_back());
        end
    endfunction

    task automatic send_text(logic [7:0] b, logic fend, logic typed, kind_t tk);
        field_result_t r;
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_frame_end <= fend;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        if (fend) n_frames++;
        extract_byte(b, fend);
        if (typed) begin
            r.kind  = tk;
            r.vbyte = 8'h00;
            r.last  = 1'b1;
            extracted_q.push_back(r);
        end else begin
            foreach (byte_results[i]) extracted_q.push_back(byte_results[i]);
        end
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic send_frame();
        foreach (frame_text[i])
            send_text(frame_text[i], i == frame_text.size() - 1, 1'b0, KIND_BYTE);
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_KEY_LENGTH:     key_len_q = data[4:0];
            CFG_KEY_BYTES_LOW:  key_lo_q  = data;
            CFG_KEY_BYTES_HIGH: key_hi_q  = data;
            default: ;
        endcase
    endtask

    task automatic load_key(logic [4:0] len, logic [63:0] lo, logic [63:0] hi);
        cfg_put(CFG_KEY_LENGTH, {59'd0, len});
        cfg_put(CFG_KEY_BYTES_LOW, lo);
        cfg_put(CFG_KEY_BYTES_HIGH, hi);
        cfg_valid <= 1'b0;
    endtask

    // stop offering text until every result is back, then let the pipe settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (extracted_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_result();
        field_result_t want;
        kind_seen[m_kind]++;
        if (extracted_q.size() == 0) begin
            if (err_count < 10)
                $display("unexpected result: kind %0d byte %02h last %0b",
                         m_kind, m_value_byte, m_last_of_run);
            err_count++;
        end else begin
            want = extracted_q.pop_front();
            if (m_kind != want.kind || m_value_byte != want.vbyte ||
                m_last_of_run != want.last) begin
                if (err_count < 10)
                    $display({"mismatch: expected kind %0d byte %02h last %0b, ",
                              "got kind %0d byte %02h last %0b"},
                             want.kind, want.vbyte, want.last,
                             m_kind, m_value_byte, m_last_of_run);
                err_count++;
            end
        end
    endtask

    // result side: checks each transfer and applies backpressure
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (aresetn && m_valid && m_ready) check_result();
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                         quiet, extracted_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int          goal;
        bit          paused;
        logic [4:0]  klen;
        logic [63:0] klo;
        logic [63:0] khi;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_KEY_LENGTH;
        cfg_data    <= 64'd0;
        s_valid     <= 1'b0;
        s_text_byte <= 8'h00;
        s_frame_end <= 1'b0;
        foreach (recent_text[i]) recent_text[i] = 8'h00;
        pmode     = PM_SEARCH;
        hex_seen  = 0;
        key_len_q = 5'd0;
        key_lo_q  = 64'd0;
        key_hi_q  = 64'd0;
        paused    = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
            send_text(DIRECTED[i].ch, DIRECTED[i].fend, DIRECTED[i].typed, DIRECTED[i].want);
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin klen = 5'd0;  klo = {$urandom, $urandom}; khi = {$urandom, $urandom}; end
                1: begin klen = 5'd16; klo = letters64(); khi = letters64(); end
                // oversized length, clamps to the full sixteen bytes
                2: begin klen = 5'd31; klo = {$urandom, $urandom}; khi = {$urandom, $urandom}; end
                3: begin klen = 5'd1;  klo = '1; khi = '0; end
                4: begin klen = 5'($urandom_range(2, 15)); klo = letters64(); khi = letters64(); end
                default: begin
                    klen = 5'($urandom_range(1, 6)); klo = letters64(); khi = letters64();
                end
            endcase
            idle_on = (ph != 5);
            load_key(klen, klo, khi);
            if (ph == 1) hold_req = 120;
            goal = n_items + PHASE_ITEMS;
            while (n_items < goal) begin
                if (ph == 2 && !paused && n_items >= goal - PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                build_frame();
                send_frame();
            end
            drain_results();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run: %0d text bytes in %0d frames over 7 key settings (empty, full, oversized)",
                 n_items, n_frames);
        $display("results: %0d value bytes, %0d closed, %0d cut, %0d not found",
                 kind_seen[KIND_BYTE], kind_seen[KIND_CLOSED], kind_seen[KIND_CUT],
                 kind_seen[KIND_NOT_FOUND]);
        if (err_count == 0 && extracted_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[json_string_field_extractor.f]
hdl/jsfe_pkg.sv
hdl/jsfe_front.sv
hdl/jsfe_queue.sv
hdl/jsfe_back.sv
hdl/json_string_field_extractor.sv
sim/tb.sv
